// ===== sv/obst_pkg.sv =====
package obst_pkg;

    localparam int MAX_KEYS = 32;
    localparam int SPAN     = MAX_KEYS + 1;
    localparam int FREQ_W   = 16;
    localparam int COST_W   = 27;
    localparam int KEY_W    = $clog2(MAX_KEYS);
    localparam int CNT_W    = $clog2(MAX_KEYS + 1);
    localparam int SUM_W    = FREQ_W + KEY_W;
    localparam int CADDR_W  = $clog2(SPAN * SPAN);
    localparam int BEST_W   = COST_W + 1;
    localparam int TOTAL_W  = BEST_W + 1;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    typedef struct packed {
        logic [FREQ_W-1:0] frequency;
        logic              last_key;
    } item_t;

    typedef struct packed {
        logic [COST_W-1:0] min_cost;
        logic              too_many;
    } result_t;

    // Half-open range [lo, hi) maps to entry lo * SPAN + hi.
    function automatic logic [CADDR_W-1:0] cost_idx(input logic [CNT_W-1:0] lo,
                                                    input logic [CNT_W-1:0] hi);
        logic [CADDR_W-1:0] idx;
        idx = CADDR_W'(lo) * CADDR_W'(SPAN) + CADDR_W'(hi);
        return idx;
    endfunction

endpackage

// ===== sv/obst_ram.sv =====
module obst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/optimal_bst_cost_core.sv =====
// Optimal binary search tree cost.
// Keys arrive in ascending order, one frequency per transfer on item. A
// transfer happens at a rising edge with start high and busy low. Each
// frequency is added to a running sum and the prefix sum is stored; at most
// MAX_KEYS keys are kept, further ones are dropped and flag too_many.
// A transfer with last_key set raises busy and starts the table fill over
// all subranges by length; each range [lo, hi) takes two prefix-sum reads,
// two cost-memory reads per candidate root, one from each of two copies of
// the cost memory, and one write.
// The result appears on result for one cycle with done high, in the first
// cycle with busy low; the receiver cannot stall it. Loading takes one cycle
// a key.
// The memories need no clearing: empty subranges read as zero by address
// compare, so busy is low right after reset, which clears count and flags.
module optimal_bst_cost_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  obst_pkg::item_t   item,
    output logic              busy,
    output logic              done,
    output obst_pkg::result_t result
);
    import obst_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PRD   = 5'b00010,
        S_PSUM  = 5'b00100,
        S_SCAN  = 5'b01000,
        S_WRITE = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              ovf_reg, ovf_next;
    logic [SUM_W-1:0]  run_sum_reg, run_sum_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  r_reg, r_next;
    logic              pend_reg, pend_next;
    logic [CNT_W-1:0]  pend_r_reg, pend_r_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [BEST_W-1:0] best_reg, best_next;
    logic              done_reg, done_next;
    result_t           result_reg, result_next;

    logic [CNT_W-1:0]   hi;
    logic [CNT_W-1:0]   hi_m1;
    logic [CNT_W-1:0]   lo_m1;
    logic               accept;
    logic               issue;
    logic               p_we;
    logic [SUM_W-1:0]   p_wdata;
    logic [SUM_W-1:0]   pa_rdata;
    logic [SUM_W-1:0]   pb_rdata;
    logic               c_we;
    logic [CADDR_W-1:0] c_waddr;
    logic [COST_W-1:0]  c_wdata;
    logic [CADDR_W-1:0] ca_raddr;
    logic [CADDR_W-1:0] cb_raddr;
    logic [COST_W-1:0]  ca_rdata;
    logic [COST_W-1:0]  cb_rdata;
    logic [BEST_W-1:0]  left_cost;
    logic [BEST_W-1:0]  right_cost;
    logic [BEST_W-1:0]  cand;
    logic [TOTAL_W-1:0] total;
    logic [COST_W-1:0]  clamped;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;
    assign accept = start && !busy;

    assign hi    = lo_reg + len_reg;
    assign hi_m1 = hi - CNT_W'(1);
    assign lo_m1 = lo_reg - CNT_W'(1);
    assign issue = (r_reg < hi);

    assign p_we    = accept && (cnt_reg < CNT_W'(MAX_KEYS));
    assign p_wdata = run_sum_reg + SUM_W'(item.frequency);

    assign ca_raddr = cost_idx(lo_reg, r_reg);
    assign cb_raddr = cost_idx(r_reg + CNT_W'(1), hi);

    assign left_cost  = (pend_r_reg == lo_reg) ? '0 : BEST_W'(ca_rdata);
    assign right_cost = (pend_r_reg == hi_m1) ? '0 : BEST_W'(cb_rdata);
    assign cand       = left_cost + right_cost;

    assign total   = TOTAL_W'(best_reg) + TOTAL_W'(sum_reg);
    assign clamped = (total > TOTAL_W'(COST_MAX)) ? COST_MAX : total[COST_W-1:0];

    assign c_we    = (state_reg == S_WRITE);
    assign c_waddr = cost_idx(lo_reg, hi);
    assign c_wdata = clamped;

    // Two copies of each memory give two reads a cycle.
    obst_ram #(.WIDTH(SUM_W), .DEPTH(MAX_KEYS)) u_prefix_a (
        .clk   (clk),
        .we    (p_we),
        .waddr (cnt_reg[KEY_W-1:0]),
        .wdata (p_wdata),
        .raddr (hi_m1[KEY_W-1:0]),
        .rdata (pa_rdata)
    );

    obst_ram #(.WIDTH(SUM_W), .DEPTH(MAX_KEYS)) u_prefix_b (
        .clk   (clk),
        .we    (p_we),
        .waddr (cnt_reg[KEY_W-1:0]),
        .wdata (p_wdata),
        .raddr (lo_m1[KEY_W-1:0]),
        .rdata (pb_rdata)
    );

    obst_ram #(.WIDTH(COST_W), .DEPTH(SPAN * SPAN)) u_cost_a (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (ca_raddr),
        .rdata (ca_rdata)
    );

    obst_ram #(.WIDTH(COST_W), .DEPTH(SPAN * SPAN)) u_cost_b (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (cb_raddr),
        .rdata (cb_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        run_sum_next = run_sum_reg;
        n_next       = n_reg;
        len_next     = len_reg;
        lo_next      = lo_reg;
        r_next       = r_reg;
        pend_next    = 1'b0;
        pend_r_next  = pend_r_reg;
        sum_next     = sum_reg;
        best_next    = best_reg;
        done_next    = 1'b0;
        result_next  = result_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (p_we)
                    begin
                        cnt_next     = cnt_reg + CNT_W'(1);
                        run_sum_next = p_wdata;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (item.last_key)
                    begin
                        n_next     = p_we ? cnt_reg + CNT_W'(1) : cnt_reg;
                        len_next   = CNT_W'(1);
                        lo_next    = '0;
                        state_next = S_PRD;
                    end
                end
            end
            S_PRD:
            begin
                state_next = S_PSUM;
            end
            S_PSUM:
            begin
                sum_next   = pa_rdata - ((lo_reg == '0) ? '0 : pb_rdata);
                r_next     = lo_reg;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    r_next    = r_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end
                pend_r_next = r_reg;
                if (pend_reg)
                begin
                    if ((pend_r_reg == lo_reg) || (cand < best_reg))
                    begin
                        best_next = cand;
                    end
                    if (pend_r_reg == hi_m1)
                    begin
                        state_next = S_WRITE;
                    end
                end
            end
            S_WRITE:
            begin
                if (len_reg == n_reg)
                begin
                    done_next            = 1'b1;
                    result_next.min_cost = clamped;
                    result_next.too_many = ovf_reg;
                    cnt_next             = '0;
                    ovf_next             = 1'b0;
                    run_sum_next         = '0;
                    state_next           = S_IDLE;
                end
                else
                begin
                    if (hi == n_reg)
                    begin
                        len_next = len_reg + CNT_W'(1);
                        lo_next  = '0;
                    end
                    else
                    begin
                        lo_next = lo_reg + CNT_W'(1);
                    end
                    state_next = S_PRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            run_sum_reg <= '0;
            pend_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            run_sum_reg <= run_sum_next;
            pend_reg    <= pend_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        len_reg    <= len_next;
        lo_reg     <= lo_next;
        r_reg      <= r_next;
        pend_r_reg <= pend_r_next;
        sum_reg    <= sum_next;
        best_reg   <= best_next;
        result_reg <= result_next;
    end

`ifndef NO_ASSERTIONS
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_KEYS))
        else $error("key count above capacity");

    a_done_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_WRITE))
        else $error("result without a final table write");

    a_scan_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (r_reg <= hi))
        else $error("root index past range end");
`endif

endmodule

// ===== verif/bst_cost_checker.sv =====
module bst_cost_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  obst_pkg::item_t   item,
    input  logic              done,
    input  obst_pkg::result_t result,
    output int                errors,
    output int                pending
);
    import obst_pkg::*;

    logic [FREQ_W-1:0] key_freq [MAX_KEYS];
    int                keys_held;
    logic              keys_dropped;
    result_t           cost_q [$];

    // Bottom-up table over half-open key ranges [lo, hi), ordered by length.
    function automatic logic [COST_W-1:0] optimal_cost(input int n);
        longint unsigned cost [SPAN][SPAN];
        longint unsigned weight [SPAN][SPAN];
        longint unsigned best;
        longint unsigned cand;
        int              len;
        int              lo;
        int              hi;
        int              r;
        for (lo = 0; lo <= n; lo++)
        begin
            cost[lo][lo] = 0;
            weight[lo][lo] = 0;
        end
        for (len = 1; len <= n; len++)
        begin
            for (lo = 0; lo + len <= n; lo++)
            begin
                hi = lo + len;
                weight[lo][hi] = weight[lo][hi-1] + key_freq[hi-1];
                best = cost[lo][lo] + cost[lo+1][hi];
                for (r = lo + 1; r < hi; r++)
                begin
                    cand = cost[lo][r] + cost[r+1][hi];
                    if (cand < best)
                        best = cand;
                end
                cost[lo][hi] = best + weight[lo][hi];
            end
        end
        if (cost[0][n] > COST_MAX)
            return COST_MAX;
        return COST_W'(cost[0][n]);
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        errors++;
        $display("bst_cost_checker: %s: got %0d, want %0d at %0t", what, got, want, $time);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            keys_held = 0;
            keys_dropped = 1'b0;
            cost_q.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                if (cost_q.size() == 0)
                begin
                    flag_mismatch("result with none pending", 32'(result.min_cost), '0);
                end
                else
                begin
                    want = cost_q.pop_front();
                    if (result.min_cost !== want.min_cost)
                        flag_mismatch("min_cost", 32'(result.min_cost), 32'(want.min_cost));
                    if (result.too_many !== want.too_many)
                        flag_mismatch("too_many", 32'(result.too_many), 32'(want.too_many));
                end
            end
            if (start && !busy)
            begin
                if (keys_held < MAX_KEYS)
                begin
                    key_freq[keys_held] = item.frequency;
                    keys_held++;
                end
                else
                begin
                    keys_dropped = 1'b1;
                end
                if (item.last_key)
                begin
                    want.min_cost = optimal_cost(keys_held);
                    want.too_many = keys_dropped;
                    cost_q.push_back(want);
                    keys_held = 0;
                    keys_dropped = 1'b0;
                end
            end
            pending = cost_q.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    import obst_pkg::*;

    localparam int TOTAL_KEYS  = 1950;
    localparam int STALL_LIMIT = 40000;
    localparam int TAIL_CYCLES = 20;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    item_t   item = '0;
    logic    busy;
    logic    done;
    result_t result;
    int      errors;
    int      pending;
    int      keys_sent = 0;
    int      sets_sent = 0;
    int      overflow_sets = 0;
    int      set_len = 0;
    int      stall_count = 0;

    always #4 clk = ~clk;

    optimal_bst_cost_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    bst_cost_checker u_chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .done    (done),
        .result  (result),
        .errors  (errors),
        .pending (pending)
    );

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("tb_top: no transfer for %0d cycles", STALL_LIMIT);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    function automatic logic [FREQ_W-1:0] pick_freq();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 16)
            return '1;
        if (r < 28)
            return FREQ_W'($urandom_range(0, 15));
        return FREQ_W'($urandom);
    endfunction

    function automatic int pick_set_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(1, 4);
        if (r < 85)
            return $urandom_range(5, 12);
        if (r < 95)
            return $urandom_range(13, MAX_KEYS - 1);
        return $urandom_range(MAX_KEYS, MAX_KEYS + 8);
    endfunction

    task automatic send_key(input logic [FREQ_W-1:0] freq, input logic lst);
        int idle_pct;
        idle_pct = keys_sent < 650 ? 12 : (keys_sent < 1300 ? 70 : 0);
        while ($urandom_range(1, 100) <= idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item <= {freq, lst};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        keys_sent++;
        set_len++;
        if (lst)
        begin
            sets_sent++;
            if (set_len > MAX_KEYS)
                overflow_sets++;
            set_len = 0;
        end
    endtask

    task automatic send_set(input int n_keys, input bit all_max);
        int k;
        for (k = 0; k < n_keys; k++)
            send_key(all_max ? {FREQ_W{1'b1}} : pick_freq(), k == n_keys - 1);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single keys at both extremes
        send_key('0, 1'b1);
        send_key('1, 1'b1);
        // short sets, some with heavy keys at either end
        send_key(16'd1, 1'b0);
        send_key('1, 1'b1);
        send_key('1, 1'b0);
        send_key('0, 1'b0);
        send_key('1, 1'b1);
        send_key(16'd3, 1'b0);
        send_key(16'd1, 1'b0);
        send_key(16'd4, 1'b0);
        send_key(16'd1, 1'b0);
        send_key(16'd5, 1'b1);
        send_key('0, 1'b0);
        send_key('0, 1'b1);
        // store exactly full, overflowing on the last key only, full well before the last key
        send_set(MAX_KEYS, 1'b1);
        send_set(MAX_KEYS + 1, 1'b0);
        send_set(MAX_KEYS + 4, 1'b1);

        while (keys_sent < TOTAL_KEYS)
            send_set(pick_set_size(), $urandom_range(0, 99) < 5);
        start <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("tb_top: %0d keys in %0d sets, %0d sets ran past the %0d-key store",
                 keys_sent, sets_sent, overflow_sets, MAX_KEYS);
        $display("tb_top: sender paced at 12%%, then 70%%, then no idle cycles");
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/obst_pkg.sv
sv/obst_ram.sv
sv/optimal_bst_cost_core.sv
verif/bst_cost_checker.sv
verif/tb_top.sv
